// ===== rtl/core/hse_pkg.sv =====
`default_nettype none

package hse_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 24;

    localparam int OPCODE_W = 2;
    localparam int SYMBOL_W = 8;
    localparam int CODE_W   = 24;
    localparam int LEN_W    = 5;
    localparam int BYTE_W   = 8;

    localparam int OPCODE_LSB = 0;
    localparam int SYMBOL_LSB = OPCODE_LSB + OPCODE_W;
    localparam int CODE_LSB   = SYMBOL_LSB + SYMBOL_W;
    localparam int LEN_LSB    = CODE_LSB + CODE_W;
    localparam int IN_FIELDS_W = LEN_LSB + LEN_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

    localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int ENTRY_W   = LEN_W + CODE_W;

    localparam int PEND_W = BYTE_W - 1;
    localparam int PCNT_W = $clog2(BYTE_W);
    localparam int ACC_W  = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W  = $clog2(ACC_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef enum logic {
        ITEM_ENCODE,
        ITEM_FLUSH
    } item_kind_t;

    typedef struct packed {
        item_kind_t              kind;
        logic [CODE_W-1:0]       code;
        logic [LEN_W-1:0]        len;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/huffman_symbol_encoder_unit.sv =====
// Channel   Direction  Width  Contents
// s_axis    in         40     tdata: opcode, symbol, code_bits, code_length
// m_axis    out        8      tdata: packed_byte; tlast: last_of_run
//
// One input beat per cycle is accepted while the bit packer keeps up.
// An encode that completes k bytes holds the packer until all k are sent, one byte per output beat.
// Loads, unused opcodes and absent symbols pass through the table stage only and never reach the queue.
// An input beat passes the table read register, the queue and the output byte register before its first output beat.
// Reset clears the table valid bits at once, so no clearing pass follows it.
// A stalled output fills the four-entry queue before the input side stalls.
`default_nettype none

module huffman_symbol_encoder_unit
    import hse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // opcode [1:0], symbol [9:2], code_bits [33:10], code_length [38:34], zero [39]
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // packed_byte [7:0]
    output logic [BYTE_W-1:0]          m_axis_tdata,
    output logic                       m_axis_tlast
);

    q_status_t q_stat;
    q_entry_t  q_push_entry;
    q_entry_t  q_pop_entry;
    logic      q_push;
    logic      q_pop;

    hse_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_stat        (q_stat),
        .push_valid    (q_push),
        .push_entry    (q_push_entry)
    );

    hse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .stat       (q_stat)
    );

    hse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .pop_entry     (q_pop_entry),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTH
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("packer popped an empty queue");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && !s_axis_tready) |-> q_stat.full)
        else $error("input stalled while the queue had room");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/hse_ram.sv =====
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hse_front.sv =====
`default_nettype none

module hse_front
    import hse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire q_status_t             q_stat,
    output logic                       push_valid,
    output q_entry_t                   push_entry
);

    opcode_t              in_op;
    logic [SYMBOL_W-1:0]  in_sym;
    logic [CODE_W-1:0]    in_code;
    logic [LEN_W-1:0]     in_len;
    logic [LEN_W-1:0]     len_sat;
    logic [CODE_W-1:0]    code_masked;
    logic                 in_range;
    logic [SYM_IDX_W-1:0] in_idx;
    logic                 accept;
    logic                 s1_free;
    logic                 tbl_we;
    logic [ENTRY_W-1:0]   rd_entry;
    logic [LEN_W-1:0]     rd_len;
    logic [CODE_W-1:0]    rd_code;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    opcode_t                 s1_op_reg;
    logic                    s1_hit_reg;
    logic [SYMBOL_COUNT-1:0] valid_reg;

    assign in_op   = opcode_t'(s_axis_tdata[OPCODE_LSB +: OPCODE_W]);
    assign in_sym  = s_axis_tdata[SYMBOL_LSB +: SYMBOL_W];
    assign in_code = s_axis_tdata[CODE_LSB +: CODE_W];
    assign in_len  = s_axis_tdata[LEN_LSB +: LEN_W];

    assign in_range = ({1'b0, in_sym} < (SYMBOL_W + 1)'(SYMBOL_COUNT));
    assign in_idx   = in_sym[SYM_IDX_W-1:0];
    assign len_sat  = (in_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : in_len;

    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            code_masked[i] = in_code[i] & (i < int'(len_sat));
        end
    end

    assign rd_len  = rd_entry[ENTRY_W-1 -: LEN_W];
    assign rd_code = rd_entry[CODE_W-1:0];

    assign push_valid = s1_valid_reg &&
                        ((s1_op_reg == OP_ENCODE && s1_hit_reg && rd_len != '0) ||
                         s1_op_reg == OP_FLUSH);
    assign push_entry.kind = (s1_op_reg == OP_FLUSH) ? ITEM_FLUSH : ITEM_ENCODE;
    assign push_entry.code = rd_code;
    assign push_entry.len  = rd_len;

    assign s1_free       = !s1_valid_reg || !push_valid || !q_stat.full;
    assign s_axis_tready = s1_free;
    assign accept        = s_axis_tvalid && s1_free;
    assign tbl_we        = accept && in_op == OP_LOAD && in_range;
    assign s1_valid_next = s1_free ? accept : s1_valid_reg;

    hse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (in_idx),
        .wdata ({len_sat, code_masked}),
        .re    (accept),
        .raddr (in_idx),
        .rdata (rd_entry)
    );

    // A symbol whose entry was never loaded reads as absent through its valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= OP_LOAD;
            s1_hit_reg   <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_op_reg  <= in_op;
                s1_hit_reg <= in_range && valid_reg[in_idx];
            end
            if (tbl_we)
            begin
                valid_reg[in_idx] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hse_queue.sv =====
`default_nettype none

module hse_queue
    import hse_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push_valid,
    input  wire q_entry_t push_entry,
    input  wire logic     pop,
    output q_entry_t      pop_entry,
    output q_status_t     stat
);

    q_entry_t             slots_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 push_fire;
    logic                 pop_fire;

    assign stat.full      = (count_reg == Q_CNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);
    assign push_fire      = push_valid && !stat.full;
    assign pop_fire       = pop && stat.not_empty;
    assign pop_entry      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hse_back.sv =====
`default_nettype none

module hse_back
    import hse_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire q_status_t         q_stat,
    input  wire q_entry_t          pop_entry,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [BYTE_W-1:0]      m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic                busy_reg,      busy_next;
    logic [ACC_W-1:0]    acc_reg,       acc_next;
    logic [TOT_W-1:0]    total_reg,     total_next;
    logic [PEND_W-1:0]   pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0]   pend_cnt_reg,  pend_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]   out_byte_reg,  out_byte_next;
    logic                out_last_reg,  out_last_next;

    logic                load_out;
    logic [ACC_W-1:0]    new_acc;
    logic [TOT_W-1:0]    new_total;
    logic [ACC_W-1:0]    src_acc;
    logic [TOT_W-1:0]    src_total;
    logic [BYTE_W-1:0]   emit_byte;
    logic [TOT_W-1:0]    rest;
    logic                rest_small;
    logic [PEND_W-1:0]   rest_mask;
    logic [BYTE_W-1:0]   flush_byte;

    assign load_out   = !out_valid_reg || m_axis_tready;
    assign new_acc    = (ACC_W'(pend_bits_reg) << pop_entry.len) | ACC_W'(pop_entry.code);
    assign new_total  = TOT_W'(pend_cnt_reg) + TOT_W'(pop_entry.len);
    assign src_acc    = busy_reg ? acc_reg : new_acc;
    assign src_total  = busy_reg ? total_reg : new_total;
    assign rest       = src_total - TOT_W'(BYTE_W);
    assign emit_byte  = BYTE_W'(src_acc >> rest);
    assign rest_small = (rest < TOT_W'(BYTE_W));
    assign rest_mask  = (PEND_W'(1) << rest) - PEND_W'(1);
    assign flush_byte = BYTE_W'({pend_bits_reg, 1'b0} << (PCNT_W'(BYTE_W - 1) - pend_cnt_reg));

    always_comb
    begin
        busy_next      = busy_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_valid_next = load_out ? 1'b0 : out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        if (busy_reg)
        begin
            if (load_out)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = emit_byte;
                out_last_next  = rest_small;
                total_next     = rest;
                if (rest_small)
                begin
                    busy_next      = 1'b0;
                    pend_bits_next = PEND_W'(src_acc) & rest_mask;
                    pend_cnt_next  = rest[PCNT_W-1:0];
                end
            end
        end
        else if (q_stat.not_empty)
        begin
            case (pop_entry.kind)
                ITEM_ENCODE:
                begin
                    if (new_total < TOT_W'(BYTE_W))
                    begin
                        pop            = 1'b1;
                        pend_bits_next = PEND_W'(new_acc);
                        pend_cnt_next  = new_total[PCNT_W-1:0];
                    end
                    else if (load_out)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = emit_byte;
                        out_last_next  = rest_small;
                        if (rest_small)
                        begin
                            pend_bits_next = PEND_W'(src_acc) & rest_mask;
                            pend_cnt_next  = rest[PCNT_W-1:0];
                        end
                        else
                        begin
                            busy_next  = 1'b1;
                            acc_next   = new_acc;
                            total_next = rest;
                        end
                    end
                end
                ITEM_FLUSH:
                begin
                    if (pend_cnt_reg == '0)
                    begin
                        pop = 1'b1;
                    end
                    else if (load_out)
                    begin
                        pop            = 1'b1;
                        out_valid_next = 1'b1;
                        out_byte_next  = flush_byte;
                        out_last_next  = 1'b1;
                        pend_bits_next = '0;
                        pend_cnt_next  = '0;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            total_reg     <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            total_reg     <= total_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import hse_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } byte_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [BYTE_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;

    logic [CODE_W-1:0] code_lut [SYMBOL_COUNT];
    int unsigned       len_lut  [SYMBOL_COUNT];
    logic [BYTE_W-1:0] held_bits;
    int unsigned       held_count;

    byte_beat_t        expected_bytes[$];
    logic [SYMBOL_W-1:0] loaded_symbols[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cycle_count;
    int unsigned error_count;
    int unsigned beats_sent;
    int unsigned bytes_checked;

    huffman_symbol_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (recv_stall_pct == 0)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        error_count++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin
        byte_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected byte", m_axis_tdata, 0);
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_axis_tdata !== want.data)
                    report_mismatch("packed_byte", m_axis_tdata, want.data);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", m_axis_tlast, want.last);
            end
        end
    end

    // Bit packer prediction: updates the table and pending bits and queues the bytes.
    task automatic advance_packer(input logic [OPCODE_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                                  input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        int unsigned ln;
        int unsigned total;
        int unsigned nbytes;
        logic [63:0] acc;
        byte_beat_t beat;
        ln = len;
        if (op == OP_LOAD)
        begin
            if (ln > MAX_CODE_LEN)
                ln = MAX_CODE_LEN;
            len_lut[sym] = ln;
            code_lut[sym] = CODE_W'(({40'd0, code} & ((64'd1 << ln) - 64'd1)));
        end
        else if (op == OP_ENCODE && len_lut[sym] != 0)
        begin
            acc = ({57'd0, held_bits[6:0]} << len_lut[sym]) | {40'd0, code_lut[sym]};
            total = held_count + len_lut[sym];
            nbytes = total / 8;
            for (int i = 0; i < nbytes; i++)
            begin
                total -= 8;
                beat.data = BYTE_W'(acc >> total);
                beat.last = (i == nbytes - 1);
                expected_bytes.insert(expected_bytes.size(), beat);
            end
            held_bits = BYTE_W'(acc & ((64'd1 << total) - 64'd1));
            held_count = total;
        end
        else if (op == OP_FLUSH && held_count != 0)
        begin
            beat.data = BYTE_W'(held_bits << (8 - held_count));
            beat.last = 1'b1;
            expected_bytes.insert(expected_bytes.size(), beat);
            held_bits = '0;
            held_count = 0;
        end
    endtask

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [SYMBOL_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        int unsigned gap;
        logic [IN_TDATA_W-1:0] word;
        gap = 0;
        while (gap < 40 && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word = '0;
        word[OPCODE_LSB +: OPCODE_W] = op;
        word[SYMBOL_LSB +: SYMBOL_W] = sym;
        word[CODE_LSB +: CODE_W] = code;
        word[LEN_LSB +: LEN_W] = len;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        beats_sent++;
        advance_packer(op, sym, code, len);
    endtask

    task automatic test_empty_after_reset();
        send_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h7e, 24'hffffff, 5'd31);
        send_item(OP_UNUSED, 8'hff, 24'hffffff, 5'd31);
    endtask

    task automatic test_table_extremes();
        send_item(OP_LOAD, 8'hff, 24'hffffff, 5'd24);
        send_item(OP_LOAD, 8'h00, 24'h000055, 5'd7);
        send_item(OP_LOAD, 8'h80, 24'habcdef, 5'd31);
        send_item(OP_LOAD, 8'h01, 24'hffffff, 5'd3);
        send_item(OP_LOAD, 8'h02, 24'h000000, 5'd1);
        send_item(OP_LOAD, 8'h10, 24'h5a5aa5, 5'd8);
        send_item(OP_LOAD, 8'h20, 24'h123456, 5'd0);
    endtask

    task automatic test_encode_and_flush();
        send_item(OP_ENCODE, 8'h10, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h00, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'hff, 24'h000000, 5'd0);
        send_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h80, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h02, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h02, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h20, 24'h000000, 5'd0);
        send_item(OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_item(OP_LOAD, 8'h01, 24'hffffff, 5'd0);
        send_item(OP_ENCODE, 8'h01, 24'h000000, 5'd0);
        send_item(OP_FLUSH, 8'hff, 24'hffffff, 5'd31);
        send_item(OP_FLUSH, 8'h00, 24'h000000, 5'd0);
    endtask

    task automatic load_random_entry(input bit long_allowed);
        logic [SYMBOL_W-1:0] sym;
        logic [LEN_W-1:0] len;
        sym = SYMBOL_W'($urandom_range(255));
        if (long_allowed && $urandom_range(3) == 0)
            len = LEN_W'($urandom_range(31));
        else
            len = LEN_W'($urandom_range(12, 1));
        send_item(OP_LOAD, sym, CODE_W'($urandom()), len);
        if (len != 0)
            loaded_symbols.insert(loaded_symbols.size(), sym);
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        logic [SYMBOL_W-1:0] sym;
        for (int i = 0; i < 8; i++)
            load_random_entry(i >= 6);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                load_random_entry(1'b1);
            else if (pick < 78 && loaded_symbols.size() != 0)
            begin
                sym = loaded_symbols[$urandom_range(loaded_symbols.size() - 1)];
                send_item(OP_ENCODE, sym, CODE_W'($urandom()), LEN_W'($urandom()));
            end
            else if (pick < 88)
                send_item(OP_FLUSH, SYMBOL_W'($urandom()), CODE_W'($urandom()),
                          LEN_W'($urandom()));
            else if (pick < 94)
                send_item(OP_ENCODE, SYMBOL_W'($urandom()), CODE_W'($urandom()),
                          LEN_W'($urandom()));
            else
                send_item(OP_UNUSED, SYMBOL_W'($urandom()), CODE_W'($urandom()),
                          LEN_W'($urandom()));
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        m_axis_tready <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        error_count = 0;
        beats_sent = 0;
        bytes_checked = 0;
        held_bits = '0;
        held_count = 0;
        for (int i = 0; i < SYMBOL_COUNT; i++)
        begin
            code_lut[i] = '0;
            len_lut[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_after_reset();
        test_table_extremes();
        test_encode_and_flush();

        test_random_traffic(100);
        send_idle_pct = 73;
        test_random_traffic(100);
        send_idle_pct = 0;
        recv_stall_pct = 73;
        test_random_traffic(100);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        test_random_traffic(100);

        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d input beats sent, %0d output bytes checked, %0d mismatches",
                 beats_sent, bytes_checked, error_count);
        $display("covered table extremes, empty flushes, absent symbols and four idle/stall mixes");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
